// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the LRU page replacement block.
// Needs signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lrupr_pkg.sv =====
// Package for the LRU page replacement block: fixed field widths,
// FSM state type, the scan control word and a saturating increment. No dependencies.
package lrupr_pkg;

	localparam int PAGE_FIELD_W = 16;
	localparam int SLOT_W       = 4;
	localparam int TOTAL_W      = 32;
	localparam int FC_W         = 5;
	localparam int STAMP_W      = 32;

	localparam logic [FC_W-1:0]    FC_RESET = 5'd4;
	localparam logic [TOTAL_W-1:0] SAT_MAX  = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} lrupr_state_t;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic clear;  // new reference: reset the search
		logic take;   // a frame word is on the read port this cycle
	} scan_ctl_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == SAT_MAX) ? v : v + TOTAL_W'(1);
	endfunction

endpackage

// ===== rtl/lrupr_if.sv =====
// Valid/ready channel interfaces for page references and results.
// Depends on lrupr_pkg for field widths.
interface lrupr_req_if;
	logic                                valid;
	logic                                ready;
	logic [lrupr_pkg::PAGE_FIELD_W-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [lrupr_pkg::SLOT_W-1:0]  slot;
	logic [lrupr_pkg::TOTAL_W-1:0] hit_total;
	logic [lrupr_pkg::TOTAL_W-1:0] miss_total;

	modport source (output valid, output hit, output slot, output hit_total,
		output miss_total, input ready);
	modport sink   (input valid, input hit, input slot, input hit_total,
		input miss_total, output ready);
endinterface

// ===== rtl/lrupr_frame_mem.sv =====
// Frame store: one page number and last-use stamp per frame.
// Single write port, single read port, registered read data. No dependencies.
module lrupr_frame_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lrupr_scan.sv =====
// Scan unit: walks frame words in index order, tracking the first match,
// the first free frame and the oldest stamp. Depends on lrupr_pkg.
module lrupr_scan #(
	parameter int IW = 4,
	parameter int PW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lrupr_pkg::scan_ctl_t           ctl,
	input  logic [PW-1:0]                  page,
	input  logic [IW-1:0]                  idx,
	input  logic                           ent_valid,
	input  logic [PW-1:0]                  ent_page,
	input  logic [lrupr_pkg::STAMP_W-1:0]  ent_use,
	output logic                           hit,
	output logic [IW-1:0]                  slot
);

	logic                          hit_q, free_q, have_min_q;
	logic [IW-1:0]                 hit_idx_q, free_idx_q, min_idx_q;
	logic [lrupr_pkg::STAMP_W-1:0] min_use_q;

	// search flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			have_min_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			have_min_q <= 1'b0;
		end else if (ctl.take) begin
			if (ent_valid && (ent_page == page)) begin
				hit_q <= 1'b1;
			end
			if (!ent_valid) begin
				free_q <= 1'b1;
			end
			have_min_q <= 1'b1;
		end
	end

	// candidate indices and oldest stamp; strict compare keeps lowest index
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if (!hit_q && ent_valid && (ent_page == page)) begin
				hit_idx_q <= idx;
			end
			if (!free_q && !ent_valid) begin
				free_idx_q <= idx;
			end
			if (!have_min_q || (ent_use < min_use_q)) begin
				min_use_q <= ent_use;
				min_idx_q <= idx;
			end
		end
	end

	assign hit  = hit_q;
	assign slot = hit_q ? hit_idx_q : (free_q ? free_idx_q : min_idx_q);

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// Channel  Dir   Words carried
// req      in    page (16 bits)
// rsp      out   hit, slot, hit_total, miss_total
// cfg      in    cfg_we / cfg_wdata: frame_count (5 bits)
//
// A reference is accepted, then the frame store is read once for each active
// frame, then a read drain and a write-back follow; the write-back can stall.
// The single read port of the frame store makes the frame reads sequential.
// Reset clears valid bits, clock and totals at once; no clearing pass.
// A result waiting on rsp does not block accepting the next reference; the
// write-back stalls until the result register is free.
// Depends on lrupr_pkg, lrupr_if, lrupr_frame_mem, lrupr_scan, assert_macros.svh.
`include "assert_macros.svh"
module lru_page_replacement_top #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lrupr_req_if.sink                     req,
	lrupr_rsp_if.source                   rsp,
	input  logic                          cfg_we,
	input  logic [lrupr_pkg::FC_W-1:0]    cfg_wdata
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PW = (PAGE_BITS < lrupr_pkg::PAGE_FIELD_W) ? PAGE_BITS
		: lrupr_pkg::PAGE_FIELD_W;
	localparam int DW = PW + lrupr_pkg::STAMP_W;
	localparam logic [6:0] FRAMES_W = 7'(FRAMES);

	lrupr_pkg::lrupr_state_t state_q, state_d;

	logic [lrupr_pkg::FC_W-1:0]    fc_q;
	logic [6:0]                    n_frames;
	logic [FRAMES-1:0]             valid_q;
	logic [PW-1:0]                 page_q;
	logic [lrupr_pkg::STAMP_W-1:0] clock_q;
	logic [lrupr_pkg::TOTAL_W-1:0] hits_q, faults_q;
	logic [IW-1:0]                 rd_idx_q;
	logic                          rd_s1;
	logic [IW-1:0]                 idx_s1;
	logic                          last_rd;

	logic                          accept, issue, do_write, out_valid_q;
	logic                          out_hit_q;
	logic [lrupr_pkg::SLOT_W-1:0]  out_slot_q;
	logic [lrupr_pkg::TOTAL_W-1:0] out_hits_q, out_faults_q;

	logic [DW-1:0]                 rdata;
	logic                          scan_hit;
	logic [IW-1:0]                 scan_slot;
	logic [IW+3:0]                 slot_wide;
	lrupr_pkg::scan_ctl_t          scan_ctl;

	// active frame count, clamped to 1..FRAMES
	always_comb begin
		if (fc_q == '0) begin
			n_frames = 7'd1;
		end else if ({2'b00, fc_q} > FRAMES_W) begin
			n_frames = FRAMES_W;
		end else begin
			n_frames = {2'b00, fc_q};
		end
	end

	assign last_rd = (7'(rd_idx_q) == (n_frames - 7'd1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrupr_pkg::ST_IDLE: begin
				if (req.valid) state_d = lrupr_pkg::ST_SCAN;
			end
			lrupr_pkg::ST_SCAN: begin
				if (last_rd) state_d = lrupr_pkg::ST_DRAIN;
			end
			lrupr_pkg::ST_DRAIN: begin
				state_d = lrupr_pkg::ST_WRITE;
			end
			lrupr_pkg::ST_WRITE: begin
				if (!out_valid_q || rsp.ready) state_d = lrupr_pkg::ST_IDLE;
			end
			default: state_d = lrupr_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		do_write  = 1'b0;
		case (state_q)
			lrupr_pkg::ST_IDLE:  req.ready = 1'b1;
			lrupr_pkg::ST_SCAN:  issue = 1'b1;
			lrupr_pkg::ST_DRAIN: ;
			lrupr_pkg::ST_WRITE: do_write = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrupr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= lrupr_pkg::FC_RESET;
		end else if (cfg_we) begin
			fc_q <= cfg_wdata;
		end
	end

	// reference clock, read index and read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q  <= '0;
			rd_idx_q <= '0;
			rd_s1    <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (accept) begin
				clock_q  <= lrupr_pkg::sat_inc(clock_q);
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			page_q <= req.page[PW-1:0];
		end
	end

	// frame valid bits and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			hits_q   <= '0;
			faults_q <= '0;
		end else if (do_write) begin
			valid_q[scan_slot] <= 1'b1;
			if (scan_hit) begin
				hits_q <= lrupr_pkg::sat_inc(hits_q);
			end else begin
				faults_q <= lrupr_pkg::sat_inc(faults_q);
			end
		end
	end

	lrupr_frame_mem #(
		.DEPTH (FRAMES),
		.AW    (IW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.we    (do_write),
		.waddr (scan_slot),
		.wdata ({page_q, clock_q}),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	assign scan_ctl.clear = accept;
	assign scan_ctl.take  = rd_s1;

	lrupr_scan #(
		.IW (IW),
		.PW (PW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.page      (page_q),
		.idx       (idx_s1),
		.ent_valid (valid_q[idx_s1]),
		.ent_page  (rdata[DW-1:lrupr_pkg::STAMP_W]),
		.ent_use   (rdata[lrupr_pkg::STAMP_W-1:0]),
		.hit       (scan_hit),
		.slot      (scan_slot)
	);

	assign slot_wide = {4'b0000, scan_slot};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_write) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			out_hit_q    <= scan_hit;
			out_slot_q   <= slot_wide[lrupr_pkg::SLOT_W-1:0];
			out_hits_q   <= scan_hit ? lrupr_pkg::sat_inc(hits_q) : hits_q;
			out_faults_q <= scan_hit ? faults_q : lrupr_pkg::sat_inc(faults_q);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.slot       = out_slot_q;
	assign rsp.hit_total  = out_hits_q;
	assign rsp.miss_total = out_faults_q;

	// checks
	`ASSERT_SAME(a_write_free, do_write, !out_valid_q || rsp.ready)
	`ASSERT_SAME(a_hit_resident, do_write && scan_hit, valid_q[scan_slot])
	`ASSERT_SAME(a_slot_active, do_write, 7'(scan_slot) < n_frames)
	`ASSERT_NEXT(a_drain_write, state_q == lrupr_pkg::ST_DRAIN,
		state_q == lrupr_pkg::ST_WRITE)

endmodule
